FILE: hdl/pfde_pkg.sv
`default_nettype none

package pfde_pkg;

    localparam int PAGE_COUNT   = 8;
    localparam int COLUMN_COUNT = 128;

    localparam int COL_W     = $clog2(COLUMN_COUNT);
    localparam int PG_W      = $clog2(PAGE_COUNT);
    localparam int ADDR_W    = PG_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    typedef enum logic [2:0] {
        F_CLEAR  = 3'd0,
        F_FILL   = 3'd1,
        F_SPAN   = 3'd2,
        F_G1     = 3'd3,
        F_G2     = 3'd4,
        F_BITMAP = 3'd5,
        F_READ   = 3'd6,
        F_NONE   = 3'd7
    } t_func;

    typedef struct packed {
        t_func        func;
        logic [2:0]   page;
        logic [7:0]   column;
        logic [7:0]   span_width;
        logic [7:0]   pattern;
        logic         invert;
        logic [39:0]  glyph_columns;
        logic [63:0]  bitmap_rows;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] next_column;
    } t_result;

    typedef enum logic [2:0] {
        MOP_NONE  = 3'd0,
        MOP_CLEAR = 3'd1,
        MOP_STEP  = 3'd2,
        MOP_READ  = 3'd3,
        MOP_RMW   = 3'd4
    } t_mop;

    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic cnt_inc;
        t_mop mop;
    } t_ctl;

    typedef struct packed {
        logic last;
        logic sweep_last;
        logic span_empty;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/pfde_ctrl.sv
`default_nettype none

module pfde_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  pfde_pkg::t_func  i_func,
    input  pfde_pkg::t_sts   i_sts,
    output pfde_pkg::t_ctl   o_ctl,
    output logic             busy,
    output logic             o_done
);
    import pfde_pkg::*;

    typedef enum logic [7:0] {
        S_INIT    = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_CLEAR   = 8'b0000_0100,
        S_WRITE   = 8'b0000_1000,
        S_SPAN_RD = 8'b0001_0000,
        S_SPAN_WR = 8'b0010_0000,
        S_READ    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ctl.load    = 1'b0;
        o_ctl.cnt_clr = 1'b0;
        o_ctl.cnt_inc = 1'b0;
        o_ctl.mop     = MOP_NONE;
        unique case (r_state)
            S_INIT: begin
                o_ctl.mop = MOP_CLEAR;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.cnt_clr = 1'b1;
                    unique case (i_func)
                        F_CLEAR:  n_state = S_CLEAR;
                        F_FILL:   n_state = S_WRITE;
                        F_SPAN:   n_state = S_SPAN_RD;
                        F_G1:     n_state = S_WRITE;
                        F_G2:     n_state = S_WRITE;
                        F_BITMAP: n_state = S_WRITE;
                        F_READ:   n_state = S_READ;
                        F_NONE:   n_state = S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_ctl.mop = MOP_CLEAR;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                end
            end
            S_WRITE: begin
                o_ctl.mop = MOP_STEP;
                if (i_sts.last) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                end
            end
            S_SPAN_RD: begin
                if (i_sts.span_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.mop = MOP_READ;
                    n_state   = S_SPAN_WR;
                end
            end
            S_SPAN_WR: begin
                o_ctl.mop = MOP_RMW;
                if (i_sts.last) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                    n_state       = S_SPAN_RD;
                end
            end
            S_READ: begin
                o_ctl.mop = MOP_READ;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

`default_nettype wire

FILE: hdl/pfde_dpath.sv
`default_nettype none

module pfde_dpath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  pfde_pkg::t_cmd     i_cmd,
    input  pfde_pkg::t_ctl     i_ctl,
    output pfde_pkg::t_sts     o_sts,
    output pfde_pkg::t_result  o_result
);
    import pfde_pkg::*;

    function automatic logic [7:0] pair_expand(input logic [3:0] nib);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            r[2*i]     = nib[i];
            r[2*i + 1] = nib[i];
        end
        return r;
    endfunction

    function automatic logic [7:0] glyph_byte(input logic [39:0] gl, input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = gl[7:0];
            3'd1:    b = gl[15:8];
            3'd2:    b = gl[23:16];
            3'd3:    b = gl[31:24];
            3'd4:    b = gl[39:32];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] bitmap_col(input logic [63:0] rows, input logic [2:0] c);
        logic [7:0] cb;
        cb = '0;
        for (int r = 0; r < 8; r++) begin
            cb[r] = rows[8*r + 7 - int'(c)];
        end
        return cb;
    endfunction

    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_cnt;
    logic [7:0]        r_q;
    logic [7:0]        r_mem [MEM_DEPTH];

    logic [7:0]        pg8;
    logic              pg_ok;
    logic              dbl;
    logic              rd_ok;
    logic [4:0]        k5;
    logic [7:0]        s_pg8;
    logic [7:0]        s_col;
    logic [7:0]        s_byte;
    logic              s_inv;
    logic              s_ok;
    logic [7:0]        g_byte;
    logic [7:0]        sp_col;
    logic [8:0]        end9;
    logic [8:0]        endc;
    logic [8:0]        span_n;
    logic [ADDR_W-1:0] step_last;
    logic [ADDR_W-1:0] m_addr;
    logic [7:0]        m_wd;
    logic              m_we;
    logic              m_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
        end
    end

    assign pg8   = {5'b0, r_cmd.page};
    assign pg_ok = (pg8 < 8'(PAGE_COUNT));
    assign dbl   = ((pg8 + 8'd1) < 8'(PAGE_COUNT));
    assign rd_ok = pg_ok && ({1'b0, r_cmd.column} < 9'(COLUMN_COUNT));
    assign k5    = r_cnt[4:0];

    always_comb begin
        s_pg8  = pg8;
        s_col  = r_cmd.column;
        s_byte = 8'h00;
        s_inv  = 1'b0;
        g_byte = 8'h00;
        unique case (r_cmd.func)
            F_FILL: begin
                s_col  = 8'(r_cnt);
                s_byte = r_cmd.pattern;
            end
            F_G1: begin
                s_col  = r_cmd.column + {3'b0, k5};
                s_byte = glyph_byte(r_cmd.glyph_columns, k5[2:0]);
                s_inv  = r_cmd.invert;
            end
            F_G2: begin
                s_inv = r_cmd.invert;
                if (dbl) begin
                    g_byte = glyph_byte(r_cmd.glyph_columns, k5[4:2]);
                    s_pg8  = pg8 + {7'b0, k5[1]};
                    s_col  = r_cmd.column + {4'b0, k5[4:2], k5[0]};
                    s_byte = pair_expand(k5[1] ? g_byte[7:4] : g_byte[3:0]);
                end else begin
                    s_col  = r_cmd.column + {3'b0, k5};
                    s_byte = glyph_byte(r_cmd.glyph_columns, k5[2:0]);
                end
            end
            F_BITMAP: begin
                s_col  = r_cmd.column + {5'b0, k5[2:0]};
                s_byte = bitmap_col(r_cmd.bitmap_rows, k5[2:0]);
                s_inv  = r_cmd.invert;
            end
            default: begin
                s_byte = 8'h00;
            end
        endcase
        s_ok = (s_pg8 < 8'(PAGE_COUNT)) && ({1'b0, s_col} < 9'(COLUMN_COUNT));
    end

    assign end9   = {1'b0, r_cmd.column} + {1'b0, r_cmd.span_width};
    assign endc   = (end9 > 9'(COLUMN_COUNT)) ? 9'(COLUMN_COUNT) : end9;
    assign span_n = endc - {1'b0, r_cmd.column};
    assign sp_col = r_cmd.column + 8'(r_cnt);

    always_comb begin
        unique case (r_cmd.func)
            F_FILL:   step_last = ADDR_W'(COLUMN_COUNT - 1);
            F_SPAN:   step_last = ADDR_W'(span_n - 9'd1);
            F_G1:     step_last = ADDR_W'(5);
            F_G2:     step_last = dbl ? ADDR_W'(23) : ADDR_W'(5);
            F_BITMAP: step_last = ADDR_W'(7);
            default:  step_last = '0;
        endcase
    end

    assign o_sts.last       = (r_cnt == step_last);
    assign o_sts.sweep_last = &r_cnt;
    assign o_sts.span_empty = !rd_ok || (span_n == 9'd0);

    always_comb begin
        m_addr = {pg8[PG_W-1:0], sp_col[COL_W-1:0]};
        m_wd   = 8'h00;
        m_we   = 1'b0;
        m_re   = 1'b0;
        unique case (i_ctl.mop)
            MOP_CLEAR: begin
                m_addr = r_cnt;
                m_we   = 1'b1;
            end
            MOP_STEP: begin
                m_addr = {s_pg8[PG_W-1:0], s_col[COL_W-1:0]};
                m_wd   = s_byte ^ {8{s_inv}};
                m_we   = s_ok;
            end
            MOP_READ: begin
                m_re = 1'b1;
            end
            MOP_RMW: begin
                m_wd = r_q | r_cmd.pattern;
                m_we = 1'b1;
            end
            default: begin
                m_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_addr] <= m_wd;
        end
        if (m_re) begin
            r_q <= r_mem[m_addr];
        end
    end

    always_comb begin
        o_result.read_data   = 8'h00;
        o_result.next_column = 8'h00;
        unique case (r_cmd.func)
            F_READ: o_result.read_data   = rd_ok ? r_q : 8'h00;
            F_G1:   o_result.next_column = r_cmd.column + 8'd6;
            F_G2:   o_result.next_column = r_cmd.column + (dbl ? 8'd12 : 8'd6);
            default: o_result.next_column = 8'h00;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/page_framebuffer_draw_engine.sv
// Channel   Handshake                     Payload
// command   start, taken when busy low    i_cmd (t_cmd)
// result    o_done, one-cycle strobe      o_result (t_result)
//
// One command runs at a time; each command gives one result beat, in the cycle after its work ends.
// All work goes through the one framebuffer port, a byte at a time: glyphs, bitmap and page
// fill write their columns, a span reads and then rewrites each column in range, and clear
// writes the whole framebuffer; read fetches one byte and an unused selector does no work.
// After reset the engine sweeps the framebuffer to zero with busy high.
// The receiver cannot stall; the result beat is lost if not taken in its cycle.
`default_nettype none

module page_framebuffer_draw_engine (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  pfde_pkg::t_cmd     i_cmd,
    output logic               busy,
    output logic               o_done,
    output pfde_pkg::t_result  o_result
);
    import pfde_pkg::*;

    t_ctl ctl;
    t_sts sts;

    pfde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_cmd.func),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .busy    (busy),
        .o_done  (o_done)
    );

    pfde_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_result)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_busy_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a command");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("engine idle right after reset");

endmodule

`default_nettype wire

FILE: sim/draw_result_checker.sv
`timescale 1ns / 1ps

module draw_result_checker
    import pfde_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_start,
    input  wire      i_busy,
    input  t_cmd     i_cmd,
    input  wire      i_done,
    input  t_result  i_result,
    output int       o_fail_count,
    output int       o_pending
);

    logic [7:0] pixel_bytes [PAGE_COUNT][COLUMN_COUNT];
    t_result    expected_results [$];
    t_result    predicted;
    t_result    wanted;

    function automatic void store_pixel_byte(logic [2:0] pg, logic [7:0] col,
                                             logic [7:0] value, logic inv);
        if (int'(pg) < PAGE_COUNT && int'(col) < COLUMN_COUNT) begin
            pixel_bytes[pg][col[COL_W-1:0]] = inv ? ~value : value;
        end
    endfunction

    function automatic logic [7:0] spread_nibble(logic [3:0] nib);
        logic [7:0] wide;
        wide = 8'h00;
        for (int i = 0; i < 4; i++) begin
            wide[2*i +: 2] = {2{nib[i]}};
        end
        return wide;
    endfunction

    function automatic logic [7:0] draw_glyph_1x(logic [2:0] pg, logic [7:0] col,
                                                 logic [39:0] glyph, logic inv);
        for (int i = 0; i < 5; i++) begin
            store_pixel_byte(pg, col + 8'(i), glyph[8*i +: 8], inv);
        end
        store_pixel_byte(pg, col + 8'd5, 8'h00, inv);
        return col + 8'd6;
    endfunction

    function automatic logic [7:0] draw_glyph_2x(logic [2:0] pg, logic [7:0] col,
                                                 logic [39:0] glyph, logic inv);
        logic [7:0] upper;
        logic [7:0] lower;
        logic [7:0] c0;
        if (int'(pg) + 1 >= PAGE_COUNT) begin
            return draw_glyph_1x(pg, col, glyph, inv);
        end
        for (int i = 0; i < 6; i++) begin
            upper = (i < 5) ? spread_nibble(glyph[8*i +: 4]) : 8'h00;
            lower = (i < 5) ? spread_nibble(glyph[8*i+4 +: 4]) : 8'h00;
            c0    = col + 8'(2 * i);
            store_pixel_byte(pg, c0, upper, inv);
            store_pixel_byte(pg, c0 + 8'd1, upper, inv);
            store_pixel_byte(pg + 3'd1, c0, lower, inv);
            store_pixel_byte(pg + 3'd1, c0 + 8'd1, lower, inv);
        end
        return col + 8'd12;
    endfunction

    function automatic void draw_bitmap(logic [2:0] pg, logic [7:0] col,
                                        logic [63:0] rows, logic inv);
        logic [7:0] column_byte;
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 8; r++) begin
                column_byte[r] = rows[8*r + 7 - c];
            end
            store_pixel_byte(pg, col + 8'(c), column_byte, inv);
        end
    endfunction

    function automatic t_result apply_draw_cmd(t_cmd c);
        t_result res;
        int      span_end;
        res = '0;
        case (c.func)
            F_CLEAR: begin
                for (int p = 0; p < PAGE_COUNT; p++) begin
                    for (int k = 0; k < COLUMN_COUNT; k++) begin
                        pixel_bytes[p][k] = 8'h00;
                    end
                end
            end
            F_FILL: begin
                if (int'(c.page) < PAGE_COUNT) begin
                    for (int k = 0; k < COLUMN_COUNT; k++) begin
                        pixel_bytes[c.page][k] = c.pattern;
                    end
                end
            end
            F_SPAN: begin
                if (int'(c.page) < PAGE_COUNT && int'(c.column) < COLUMN_COUNT) begin
                    span_end = int'(c.column) + int'(c.span_width);
                    if (span_end > COLUMN_COUNT) begin
                        span_end = COLUMN_COUNT;
                    end
                    for (int k = int'(c.column); k < span_end; k++) begin
                        pixel_bytes[c.page][k] = pixel_bytes[c.page][k] | c.pattern;
                    end
                end
            end
            F_G1: begin
                res.next_column = draw_glyph_1x(c.page, c.column, c.glyph_columns, c.invert);
            end
            F_G2: begin
                res.next_column = draw_glyph_2x(c.page, c.column, c.glyph_columns, c.invert);
            end
            F_BITMAP: begin
                if (int'(c.page) < PAGE_COUNT) begin
                    draw_bitmap(c.page, c.column, c.bitmap_rows, c.invert);
                end
            end
            F_READ: begin
                if (int'(c.page) < PAGE_COUNT && int'(c.column) < COLUMN_COUNT) begin
                    res.read_data = pixel_bytes[c.page][c.column[COL_W-1:0]];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAGE_COUNT; p++) begin
                for (int k = 0; k < COLUMN_COUNT; k++) begin
                    pixel_bytes[p][k] = 8'h00;
                end
            end
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, i_result);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    wanted = expected_results.pop_front();
                    if (i_result.read_data !== wanted.read_data) begin
                        $display("%0t: read_data mismatch, expected %02h actual %02h",
                                 $time, wanted.read_data, i_result.read_data);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_result.next_column !== wanted.next_column) begin
                        $display("%0t: next_column mismatch, expected %02h actual %02h",
                                 $time, wanted.next_column, i_result.next_column);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predicted = apply_draw_cmd(i_cmd);
                expected_results.push_back(predicted);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pfde_pkg::*;

    localparam int ITEM_TARGET    = 1050;
    localparam int QUIET_FROM     = 900;
    localparam int WATCHDOG_LIMIT = 8000;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    cmd;
    logic    busy;
    logic    o_done;
    t_result o_result;
    int      fail_count;
    int      pending;
    int      stall_cycles;
    int      sent;

    page_framebuffer_draw_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    draw_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic t_cmd make_cmd(t_func f, logic [2:0] pg, logic [7:0] col,
                                      logic [7:0] span, logic [7:0] pat, logic inv,
                                      logic [39:0] glyph, logic [63:0] rows);
        t_cmd c;
        c.func          = f;
        c.page          = pg;
        c.column        = col;
        c.span_width    = span;
        c.pattern       = pat;
        c.invert        = inv;
        c.glyph_columns = glyph;
        c.bitmap_rows   = rows;
        return c;
    endfunction

    function automatic logic [7:0] pick_column();
        case ($urandom_range(0, 9))
            7:       return 8'($urandom_range(116, 140));
            8:       return 8'($urandom_range(240, 255));
            9:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic t_cmd random_draw_cmd();
        t_cmd c;
        int   sel;
        sel             = $urandom_range(0, 99);
        c.page          = 3'($urandom_range(0, 7));
        c.column        = pick_column();
        c.span_width    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 16));
        c.pattern       = 8'($urandom);
        c.invert        = 1'($urandom);
        c.glyph_columns = {8'($urandom), 32'($urandom)};
        c.bitmap_rows   = {32'($urandom), 32'($urandom)};
        if (sel < 2) begin
            c.func = F_CLEAR;
        end else if (sel < 10) begin
            c.func = F_FILL;
        end else if (sel < 24) begin
            c.func = F_SPAN;
        end else if (sel < 40) begin
            c.func = F_G1;
        end else if (sel < 56) begin
            c.func = F_G2;
        end else if (sel < 70) begin
            c.func = F_BITMAP;
        end else if (sel < 96) begin
            c.func = F_READ;
        end else begin
            c.func = F_NONE;
        end
        return c;
    endfunction

    task automatic issue_cmd(input t_cmd c);
        start = 1'b1;
        cmd   = c;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic sender_gap(input bit allowed);
        if (allowed && $urandom_range(0, 2) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    initial begin
        t_cmd        c;
        t_cmd        probe;
        bit          gaps_on;
        int          reads;
        logic [39:0] ones40;
        logic [63:0] ones64;

        ones40  = '1;
        ones64  = '1;
        sent    = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        issue_cmd(make_cmd(F_READ, 3'd0, 8'd0, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_FILL, 3'd7, 8'd0, 8'd0, 8'hFF, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_READ, 3'd7, 8'd127, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_FILL, 3'd0, 8'd0, 8'd0, 8'hA0, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_SPAN, 3'd0, 8'd120, 8'd255, 8'h05, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_READ, 3'd0, 8'd127, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_SPAN, 3'd1, 8'd128, 8'd10, 8'hFF, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_SPAN, 3'd1, 8'd3, 8'd0, 8'hFF, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_SPAN, 3'd1, 8'd0, 8'd255, 8'h80, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_READ, 3'd1, 8'd3, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_G1, 3'd3, 8'd0, 8'd0, 8'h00, 1'b0, ones40, '0));
        issue_cmd(make_cmd(F_READ, 3'd3, 8'd5, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_G1, 3'd3, 8'd253, 8'd0, 8'h00, 1'b1,
                           40'h12_34_56_78_9A, '0));
        issue_cmd(make_cmd(F_READ, 3'd3, 8'd2, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_G1, 3'd2, 8'd255, 8'd0, 8'h00, 1'b0, 40'hA5_5A_0F_F0_81, '0));
        issue_cmd(make_cmd(F_G2, 3'd6, 8'd120, 8'd0, 8'h00, 1'b0,
                           40'hF1_E2_D3_C4_B5, '0));
        issue_cmd(make_cmd(F_READ, 3'd7, 8'd121, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_G2, 3'd7, 8'd10, 8'd0, 8'h00, 1'b0, 40'h3C_66_81_66_3C, '0));
        issue_cmd(make_cmd(F_READ, 3'd7, 8'd10, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_G2, 3'd4, 8'd250, 8'd0, 8'h00, 1'b1, ones40, '0));
        issue_cmd(make_cmd(F_BITMAP, 3'd2, 8'd124, 8'd0, 8'h00, 1'b0, '0,
                           64'h01_23_45_67_89_AB_CD_EF));
        issue_cmd(make_cmd(F_READ, 3'd2, 8'd125, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_BITMAP, 3'd5, 8'd252, 8'd0, 8'h00, 1'b1, '0, ones64));
        issue_cmd(make_cmd(F_READ, 3'd1, 8'd200, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_NONE, 3'd7, 8'd255, 8'd255, 8'hFF, 1'b1, ones40, ones64));
        issue_cmd(make_cmd(F_CLEAR, 3'd0, 8'd0, 8'd0, 8'h00, 1'b0, '0, '0));
        issue_cmd(make_cmd(F_READ, 3'd7, 8'd127, 8'd0, 8'h00, 1'b0, '0, '0));

        while (sent < ITEM_TARGET) begin
            gaps_on = (sent < QUIET_FROM) && (((sent / 80) % 4) != 3);
            sender_gap(gaps_on);
            c = random_draw_cmd();
            issue_cmd(c);
            if (c.func inside {F_FILL, F_SPAN, F_G1, F_G2, F_BITMAP}
                    && $urandom_range(0, 1) == 1) begin
                reads = $urandom_range(1, 3);
                for (int k = 0; k < reads; k++) begin
                    sender_gap(gaps_on);
                    probe        = c;
                    probe.func   = F_READ;
                    probe.column = c.column + 8'($urandom_range(0, 12));
                    if (c.func == F_G2 && $urandom_range(0, 1) == 1) begin
                        probe.page = c.page + 3'd1;
                    end
                    issue_cmd(probe);
                end
            end
        end
        start = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
